// File: hw/rtl/kmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kmd_pkg;

  // fixed field widths
  localparam int KEY_W  = 7;
  localparam int ROW_W  = 2;
  localparam int TIME_W = 32;
  localparam int DB_W   = 8;

  // parameter defaults
  localparam int ROWS_DEF = 4;
  localparam int COLS_DEF = 7;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] REG_DEBOUNCE_ADDR = 3'd0;
  localparam logic [DB_W-1:0]   DEBOUNCE_RST      = 8'd5;

  // item function codes
  localparam logic FUNC_SCAN      = 1'b0;
  localparam logic FUNC_ACT_RESET = 1'b1;

  typedef struct packed {
    logic              func;
    logic [ROW_W-1:0]  row_index;
    logic [KEY_W-1:0]  raw_bits;
    logic [TIME_W-1:0] now_ms;
  } kmd_in_t;

  typedef struct packed {
    logic [KEY_W-1:0]  debounced_row;
    logic [KEY_W-1:0]  changed_bits;
    logic              any_pressed;
    logic [TIME_W-1:0] activity_time;
  } kmd_out_t;

  // key bank result toward the output stage
  typedef struct packed {
    logic [KEY_W-1:0] debounced_row;
    logic [KEY_W-1:0] changed_bits;
    logic             any_pressed;
  } kmd_scan_t;

endpackage

`default_nettype wire

// File: hw/rtl/kmd_key_bank.sv
`timescale 1ns / 1ps
`default_nettype none

module kmd_key_bank #(
  parameter int ROWS = kmd_pkg::ROWS_DEF,
  parameter int COLS = kmd_pkg::COLS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire kmd_pkg::kmd_in_t           item,
  input  wire logic [kmd_pkg::DB_W-1:0]   settle_ms,
  output kmd_pkg::kmd_scan_t              res
);

  localparam int KW     = kmd_pkg::KEY_W;
  localparam int TW     = kmd_pkg::TIME_W;
  localparam int NCOL   = (COLS < KW) ? COLS : KW;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  // one bit above the row address so that ROWS itself fits for the range check
  localparam int IW     = ((ROW_AW > kmd_pkg::ROW_W) ? ROW_AW : kmd_pkg::ROW_W) + 1;

  logic [KW-1:0] stable_r  [ROWS];
  logic [KW-1:0] pending_r [ROWS];
  logic [TW-1:0] start_r   [ROWS][NCOL];

  logic [IW-1:0]     row_w;
  logic              row_ok;
  logic [ROW_AW-1:0] sel;
  logic              scan;
  logic [KW-1:0]     stable_nxt;
  logic [KW-1:0]     pending_nxt;
  logic [KW-1:0]     flip;
  logic [NCOL-1:0]   start_we;
  logic              any;

  assign row_w  = IW'(item.row_index);
  assign row_ok = (row_w < IW'(ROWS));
  assign sel    = ROW_AW'(row_w);
  assign scan   = (item.func == kmd_pkg::FUNC_SCAN) && row_ok;

  // per-column subtract and compare, all columns side by side
  always_comb begin
    logic [TW-1:0] elapsed;
    logic          rb;
    logic          db;
    logic          pb;
    stable_nxt  = stable_r[sel];
    pending_nxt = pending_r[sel];
    flip        = '0;
    start_we    = '0;
    elapsed     = '0;
    for (int c = 0; c < NCOL; c++) begin
      rb      = item.raw_bits[c];
      db      = stable_r[sel][c];
      pb      = pending_r[sel][c];
      elapsed = item.now_ms - start_r[sel][c];
      if (rb != db) begin
        if (rb != pb) begin
          pending_nxt[c] = rb;
          start_we[c]    = 1'b1;
        end else if (elapsed >= {{(TW-kmd_pkg::DB_W){1'b0}}, settle_ms}) begin
          stable_nxt[c] = rb;
          flip[c]       = 1'b1;
        end
      end else begin
        pending_nxt[c] = db;
      end
    end
  end

  // whole-matrix pressed flag, using the updated row
  always_comb begin
    any = 1'b0;
    for (int r = 0; r < ROWS; r++) begin
      if (scan && (ROW_AW'(r) == sel)) begin
        any = any | (|stable_nxt);
      end else begin
        any = any | (|stable_r[r]);
      end
    end
  end

  always_comb begin
    res.debounced_row = row_ok ? (scan ? stable_nxt : stable_r[sel]) : '0;
    res.changed_bits  = scan ? flip : '0;
    res.any_pressed   = any;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        stable_r[r]  <= '0;
        pending_r[r] <= '0;
      end
    end else if (en && scan) begin
      stable_r[sel]  <= stable_nxt;
      pending_r[sel] <= pending_nxt;
    end
  end

  // start times are only read while a pending period is open, so no reset
  always_ff @(posedge clk) begin
    if (en && scan) begin
      for (int c = 0; c < NCOL; c++) begin
        if (start_we[c]) begin
          start_r[sel][c] <= item.now_ms;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/key_matrix_debouncer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | ports                                   | dir | moves
// ---------+-----------------------------------------+-----+------------------------------
// in       | in_valid, in_ready, in_data             | in  | scan or activity-reset beat
// out      | out_valid, out_ready, out_data          | out | one result beat per input beat
// cfg      | cfg_psel/penable/pwrite/paddr/pwdata... | in  | settle time register (addr 0)
//
// an input beat sits in the input register, then is worked into the output
// register; one beat per cycle sustained while out_ready stays high
// the per-key state is read and updated in the same cycle that loads the output
// register, so beats on the same row may follow each other back to back
// out_ready low holds the output beat; the input register still takes one more
// beat, after that in_ready drops
// synchronous active-low reset clears the debounced and pending key state and last activity, and sets
// the settle time back to 5 ms

module key_matrix_debouncer #(
  parameter int ROWS = kmd_pkg::ROWS_DEF,
  parameter int COLS = kmd_pkg::COLS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire kmd_pkg::kmd_in_t             in_data,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output kmd_pkg::kmd_out_t                 out_data,
  // configuration port
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [kmd_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [kmd_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [kmd_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);

  localparam int DBW = kmd_pkg::DB_W;

  // input register
  logic             s1_v_r;
  logic             s1_v_nxt;
  kmd_pkg::kmd_in_t s1_r;

  // output register
  logic              out_v_r;
  logic              out_v_nxt;
  kmd_pkg::kmd_out_t out_r;

  logic [kmd_pkg::TIME_W-1:0] last_act_r;
  logic [kmd_pkg::TIME_W-1:0] last_act_nxt;
  logic [DBW-1:0]             debounce_r;

  logic               advance;
  logic               in_fire;
  logic               work;
  logic               cfg_wr;
  kmd_pkg::kmd_scan_t scan_res;

  // the output stage moves when it is empty or its beat is taken
  assign advance  = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || advance;
  assign in_fire  = in_valid && in_ready;
  assign work     = s1_v_r && advance;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (advance) begin
      s1_v_nxt = 1'b0;
    end
  end

  assign out_v_nxt = advance ? s1_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= in_data;
    end
  end

  kmd_key_bank #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (work),
    .item      (s1_r),
    .settle_ms (debounce_r),
    .res       (scan_res)
  );

  // activity stamp: explicit reset beat, or any debounced flip
  always_comb begin
    last_act_nxt = last_act_r;
    if (s1_r.func == kmd_pkg::FUNC_ACT_RESET) begin
      last_act_nxt = s1_r.now_ms;
    end else if (scan_res.changed_bits != '0) begin
      last_act_nxt = s1_r.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_act_r <= '0;
    end else if (work) begin
      last_act_r <= last_act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      out_r.debounced_row <= scan_res.debounced_row;
      out_r.changed_bits  <= scan_res.changed_bits;
      out_r.any_pressed   <= scan_res.any_pressed;
      out_r.activity_time <= last_act_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // configuration register, written in the access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == kmd_pkg::REG_DEBOUNCE_ADDR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= kmd_pkg::DEBOUNCE_RST;
    end else if (cfg_wr) begin
      debounce_r <= cfg_pwdata[DBW-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == kmd_pkg::REG_DEBOUNCE_ADDR) ?
                      {{(kmd_pkg::CFG_DW-DBW){1'b0}}, debounce_r} : '0;

endmodule

`default_nettype wire

// File: hw/rtl/kmd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module kmd_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire kmd_pkg::kmd_out_t          out_data,
  input wire logic                       cfg_pready
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // a pressed key in the addressed row means the matrix reports pressed
  a_any_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.debounced_row != '0) |-> out_data.any_pressed)
    else $error("debounced row pressed but any_pressed low");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled output with an occupied input stage backs up the input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && in_valid && in_ready ##1 out_valid && !out_ready
    |-> !in_ready)
    else $error("input accepted with both stages full");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");

endmodule

bind key_matrix_debouncer kmd_checker u_kmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_data   (out_data),
  .cfg_pready (cfg_pready)
);

`default_nettype wire
